// File: sv/assert_macros.svh
// assertion macros included by md5_hash_engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MD5_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("md5 assertion failed");

`define MD5_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("md5 forbidden condition seen");

`else

`define MD5_ASSERT(lbl, clk, rst_n, prop)

`define MD5_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: sv/md5_pkg.sv
// types, constants and round functions of the md5 engine
package md5_pkg;

	localparam int Rounds = 64;
	localparam int RoundBits = $clog2(Rounds);
	localparam int BlockBytes = 64;
	localparam int PosBits = $clog2(BlockBytes);
	localparam int MsgWords = BlockBytes / 4;
	localparam int WordIdxBits = $clog2(MsgWords);
	localparam int CountBits = 61;
	localparam int LenTailBytes = 8;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hEFCDAB89;
	localparam logic [31:0] IV_C = 32'h98BADCFE;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [31:0] ROUND_K [Rounds] = '{
		32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
		32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
		32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
		32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
		32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
		32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
		32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
		32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
		32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
		32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
		32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
		32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
		32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
		32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
		32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
		32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
	};

	localparam logic [4:0] ROUND_S [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	// padding view of the block buffer
	typedef enum logic [1:0] {
		PAD_NONE,
		PAD_DATA,
		PAD_DATA_LEN,
		PAD_LEN
	} pad_t;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_index;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} chain_t;

	typedef struct packed {
		logic                   we;
		logic [PosBits-1:0]     wr_pos;
		logic [7:0]             wr_byte;
		logic [WordIdxBits-1:0] rd_idx;
		pad_t                   pad;
		logic [PosBits-1:0]     fill;
	} buf_ctl_t;

	function automatic logic [3:0] msg_index(input logic [5:0] rnd);
		logic [3:0] lo;
		logic [3:0] idx;
		lo = rnd[3:0];
		case (rnd[5:4])
			2'd0: idx = lo;
			2'd1: idx = (lo << 2) + lo + 4'd1;
			2'd2: idx = (lo << 1) + lo + 4'd5;
			2'd3: idx = (lo << 3) - lo;
			default: idx = lo;
		endcase
		return idx;
	endfunction

	function automatic logic [4:0] round_shift(input logic [5:0] rnd);
		return ROUND_S[{rnd[5:4], rnd[1:0]}];
	endfunction

	function automatic logic [31:0] round_mix(input logic [1:0] phase,
		input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		case (phase)
			2'd0: f = d ^ (b & (c ^ d));
			2'd1: f = c ^ (d & (b ^ c));
			2'd2: f = b ^ c ^ d;
			2'd3: f = c ^ (b | ~d);
			default: f = b ^ c ^ d;
		endcase
		return f;
	endfunction

endpackage

// File: sv/md5_round.sv
// one md5 round step, reused for all 64 rounds of a block
module md5_round (
	input  md5_pkg::chain_t  cur,
	input  logic [31:0]      msg_word,
	input  logic [5:0]       rnd,
	output md5_pkg::chain_t  nxt
);

	logic [31:0] mix;
	logic [31:0] sum;
	logic [63:0] rot_wide;
	logic [31:0] rot;

	always_comb begin
		mix = md5_pkg::round_mix(rnd[5:4], cur.b, cur.c, cur.d);
		sum = cur.a + mix + md5_pkg::ROUND_K[rnd] + msg_word;
		rot_wide = {sum, sum} << md5_pkg::round_shift(rnd);
		rot = rot_wide[63:32];
		nxt.a = cur.d;
		nxt.b = cur.b + rot;
		nxt.c = cur.b;
		nxt.d = cur.c;
	end

endmodule

// File: sv/md5_msg_buf.sv
// block buffer with padding and length overlay on read
module md5_msg_buf (
	input  logic                                 clk,
	input  md5_pkg::buf_ctl_t                    ctl,
	input  logic [md5_pkg::CountBits-1:0]        byte_count,
	output logic [31:0]                          msg_word
);

	logic [31:0] words_q [md5_pkg::MsgWords];
	logic [31:0] raw;
	logic [md5_pkg::PosBits-1:0] pos;
	logic [7:0] b;
	logic len_view;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			words_q[ctl.wr_pos[md5_pkg::PosBits-1:2]][{ctl.wr_pos[1:0], 3'b000} +: 8]
				<= ctl.wr_byte;
		end
	end

	always_comb begin
		raw = words_q[ctl.rd_idx];
		msg_word = '0;
		len_view = (ctl.pad == md5_pkg::PAD_DATA_LEN) || (ctl.pad == md5_pkg::PAD_LEN);
		for (int j = 0; j < 4; j++) begin
			pos = {ctl.rd_idx, 2'(j)};
			if (ctl.pad == md5_pkg::PAD_NONE) begin
				b = raw[8*j +: 8];
			end else if (ctl.pad == md5_pkg::PAD_LEN) begin
				b = 8'h00;
			end else if (pos < ctl.fill) begin
				b = raw[8*j +: 8];
			end else if (pos == ctl.fill) begin
				b = md5_pkg::PAD_BYTE;
			end else begin
				b = 8'h00;
			end
			msg_word[8*j +: 8] = b;
		end
		// bit length, little-endian, in the last two words
		if (len_view && ctl.rd_idx == md5_pkg::WordIdxBits'(md5_pkg::MsgWords - 2)) begin
			msg_word = {byte_count[28:0], 3'b000};
		end else if (len_view && ctl.rd_idx == md5_pkg::WordIdxBits'(md5_pkg::MsgWords - 1)) begin
			msg_word = byte_count[md5_pkg::CountBits-1:29];
		end
	end

endmodule

// File: sv/md5_hash_engine.sv
// top level of the streaming md5 engine: sequencer, chaining words, digest output
//
// Usage:
//   req channel (req_valid, req_stall, req): one word per message byte with
//   op absorb, or op finish to pad the message and produce its digest.
//   rsp channel (rsp_valid, rsp_stall, rsp): four digest words after a
//   finish, word_index 0 to 3, last set on word 3.
// Timing:
//   an absorb word is taken while idle and leaves the engine idle; the one that
//   completes a 64-byte block is accepted, then runs 64 rounds on the shared
//   round unit and a fold. A finish runs the same steps, twice when the padding
//   spills into a second block, then the digest words leave one per cycle while
//   rsp is not stalled. The round unit does one round per cycle.
//   req_stall is high from the cycle after a finish or a block-completing
//   absorb until idle again, including the whole digest output.
// Reset:
//   arst_n clears the byte count and fill position and loads the initial
//   chaining words; no clearing pass is needed.
// Stall:
//   while rsp_stall is high during the digest output the current digest word holds and nothing moves.
`include "assert_macros.svh"

module md5_hash_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  md5_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output md5_pkg::rsp_t  rsp
);

	localparam logic [md5_pkg::RoundBits-1:0] RoundLast =
		md5_pkg::RoundBits'(md5_pkg::Rounds - 1);
	localparam logic [md5_pkg::PosBits-1:0] FillLast =
		md5_pkg::PosBits'(md5_pkg::BlockBytes - 1);
	localparam logic [md5_pkg::PosBits-1:0] LenStart =
		md5_pkg::PosBits'(md5_pkg::BlockBytes - md5_pkg::LenTailBytes);

	md5_pkg::state_t state_q, state_d;
	md5_pkg::pad_t   pad_q;
	logic [md5_pkg::RoundBits-1:0] round_q;
	logic [md5_pkg::PosBits-1:0]   fill_q;
	logic [md5_pkg::CountBits-1:0] count_q;
	logic [1:0]                    widx_q;
	md5_pkg::chain_t chain_q;
	md5_pkg::chain_t work_q;
	md5_pkg::chain_t round_nxt;
	md5_pkg::chain_t fold_sum;
	md5_pkg::buf_ctl_t buf_ctl;
	logic [31:0] msg_word;
	logic take_req;
	logic take_rsp;

	md5_msg_buf u_buf (
		.clk        (clk),
		.ctl        (buf_ctl),
		.byte_count (count_q),
		.msg_word   (msg_word)
	);

	md5_round u_round (
		.cur      (work_q),
		.msg_word (msg_word),
		.rnd      (round_q),
		.nxt      (round_nxt)
	);

	always_comb begin
		fold_sum.a = chain_q.a + work_q.a;
		fold_sum.b = chain_q.b + work_q.b;
		fold_sum.c = chain_q.c + work_q.c;
		fold_sum.d = chain_q.d + work_q.d;
	end

	always_comb begin
		buf_ctl.we = take_req && (req.op == md5_pkg::OP_ABSORB);
		buf_ctl.wr_pos = fill_q;
		buf_ctl.wr_byte = req.data_byte;
		buf_ctl.rd_idx = md5_pkg::msg_index(round_q);
		buf_ctl.pad = pad_q;
		buf_ctl.fill = fill_q;
	end

	always_comb begin
		case (widx_q)
			2'd0: rsp.digest_word = chain_q.a;
			2'd1: rsp.digest_word = chain_q.b;
			2'd2: rsp.digest_word = chain_q.c;
			2'd3: rsp.digest_word = chain_q.d;
			default: rsp.digest_word = chain_q.a;
		endcase
		rsp.word_index = widx_q;
		rsp.last = (widx_q == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= md5_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req_stall = 1'b1;
		rsp_valid = 1'b0;
		case (state_q)
			md5_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (req.op == md5_pkg::OP_FINISH || fill_q == FillLast) begin
						state_d = md5_pkg::ST_ROUND;
					end
				end
			end
			md5_pkg::ST_ROUND: begin
				if (round_q == RoundLast) begin
					state_d = md5_pkg::ST_FOLD;
				end
			end
			md5_pkg::ST_FOLD: begin
				if (pad_q == md5_pkg::PAD_DATA) begin
					state_d = md5_pkg::ST_ROUND;
				end else if (pad_q == md5_pkg::PAD_NONE) begin
					state_d = md5_pkg::ST_IDLE;
				end else begin
					state_d = md5_pkg::ST_EMIT;
				end
			end
			md5_pkg::ST_EMIT: begin
				rsp_valid = 1'b1;
				if (!rsp_stall && widx_q == 2'd3) begin
					state_d = md5_pkg::ST_IDLE;
				end
			end
			default: state_d = md5_pkg::ST_IDLE;
		endcase
	end

	assign take_req = req_valid && !req_stall;
	assign take_rsp = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= md5_pkg::PAD_NONE;
			round_q <= '0;
			fill_q <= '0;
			count_q <= '0;
			widx_q <= '0;
			chain_q <= '{md5_pkg::IV_A, md5_pkg::IV_B, md5_pkg::IV_C, md5_pkg::IV_D};
		end else begin
			if (take_req) begin
				if (req.op == md5_pkg::OP_ABSORB) begin
					fill_q <= fill_q + 1'b1;
					count_q <= count_q + 1'b1;
					pad_q <= md5_pkg::PAD_NONE;
				end else if (fill_q >= LenStart) begin
					pad_q <= md5_pkg::PAD_DATA;
				end else begin
					pad_q <= md5_pkg::PAD_DATA_LEN;
				end
			end
			if (state_q == md5_pkg::ST_ROUND) begin
				round_q <= round_q + 1'b1;
			end
			if (state_q == md5_pkg::ST_FOLD) begin
				chain_q <= fold_sum;
				if (pad_q == md5_pkg::PAD_DATA) begin
					pad_q <= md5_pkg::PAD_LEN;
				end
			end
			if (take_rsp) begin
				widx_q <= widx_q + 1'b1;
				if (widx_q == 2'd3) begin
					pad_q <= md5_pkg::PAD_NONE;
					fill_q <= '0;
					count_q <= '0;
					chain_q <= '{md5_pkg::IV_A, md5_pkg::IV_B, md5_pkg::IV_C, md5_pkg::IV_D};
				end
			end
		end
	end

	// working variables of the round loop
	always_ff @(posedge clk) begin
		case (state_q)
			md5_pkg::ST_IDLE:  work_q <= chain_q;
			md5_pkg::ST_ROUND: work_q <= round_nxt;
			md5_pkg::ST_FOLD:  work_q <= fold_sum;
			default:           work_q <= work_q;
		endcase
	end

	`MD5_NEVER(a_no_req_while_emit, clk, arst_n, rsp_valid && !req_stall)
	`MD5_ASSERT(a_idle_after_last, clk, arst_n,
		take_rsp && rsp.last |=> !rsp_valid && !req_stall)
	`MD5_ASSERT(a_round_cnt_parked, clk, arst_n,
		state_q != md5_pkg::ST_ROUND |-> round_q == '0)
	`MD5_ASSERT(a_fold_after_rounds, clk, arst_n,
		state_q == md5_pkg::ST_ROUND && round_q == RoundLast |=> state_q == md5_pkg::ST_FOLD)

endmodule

// File: sim/tb_md5_hash_engine.sv
// testbench for md5_hash_engine: streams byte messages, predicts each digest and checks every word
module tb_md5_hash_engine;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_TARGET = 410;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 150;
	localparam int REPORT_LIMIT = 10;

	localparam logic [31:0] SINE_TABLE [64] = '{
		32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
		32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
		32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
		32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
		32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
		32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
		32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
		32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
		32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
		32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
		32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
		32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
		32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
		32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
		32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
		32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
	};

	localparam int ROT_AMOUNT [16] = '{
		7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
	};

	// lengths around the padding spill and block boundaries
	localparam int SPILL_LENGTHS [10] = '{55, 56, 57, 62, 63, 64, 65, 119, 120, 128};

	class digest_scoreboard;
		logic [7:0] block_bytes [64];
		int unsigned fill;
		logic [60:0] byte_total;
		logic [31:0] chain [4];
		md5_pkg::rsp_t expected_words [$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			foreach (block_bytes[i])
				block_bytes[i] = 8'h00;
			fill = 0;
			byte_total = '0;
			chain[0] = 32'h67452301;
			chain[1] = 32'hEFCDAB89;
			chain[2] = 32'h98BADCFE;
			chain[3] = 32'h10325476;
		endfunction

		function logic [31:0] rotl(logic [31:0] v, int s);
			return (v << s) | (v >> (32 - s));
		endfunction

		function void compress_block();
			logic [31:0] msg [16];
			logic [31:0] a, b, c, d, f, t;
			int g;
			for (int i = 0; i < 16; i++)
				msg[i] = {block_bytes[4*i+3], block_bytes[4*i+2],
					block_bytes[4*i+1], block_bytes[4*i]};
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			for (int r = 0; r < 64; r++) begin
				case (r / 16)
					0: begin
						f = d ^ (b & (c ^ d));
						g = r;
					end
					1: begin
						f = c ^ (d & (b ^ c));
						g = (5 * r + 1) % 16;
					end
					2: begin
						f = b ^ c ^ d;
						g = (3 * r + 5) % 16;
					end
					default: begin
						f = c ^ (b | ~d);
						g = (7 * r) % 16;
					end
				endcase
				t = d;
				d = c;
				c = b;
				b = b + rotl(a + f + SINE_TABLE[r] + msg[g], ROT_AMOUNT[(r / 16) * 4 + r % 4]);
				a = t;
			end
			chain[0] = chain[0] + a;
			chain[1] = chain[1] + b;
			chain[2] = chain[2] + c;
			chain[3] = chain[3] + d;
		endfunction

		function void note_word(md5_pkg::req_t w);
			logic [63:0] bit_len;
			md5_pkg::rsp_t r;
			if (w.op == md5_pkg::OP_ABSORB) begin
				block_bytes[fill] = w.data_byte;
				fill = (fill + 1) % 64;
				byte_total = byte_total + 61'd1;
				if (fill == 0)
					compress_block();
			end else begin
				for (int i = fill; i < 64; i++)
					block_bytes[i] = 8'h00;
				block_bytes[fill] = 8'h80;
				// no room for the length: extra block
				if (fill >= 56) begin
					compress_block();
					foreach (block_bytes[i])
						block_bytes[i] = 8'h00;
				end
				bit_len = {byte_total, 3'b000};
				for (int k = 0; k < 8; k++)
					block_bytes[56 + k] = bit_len[8*k +: 8];
				compress_block();
				for (int k = 0; k < 4; k++) begin
					r.digest_word = chain[k];
					r.word_index = 2'(k);
					r.last = (k == 3);
					expected_words.push_back(r);
				end
				restart();
			end
		endfunction

		function void check_word(md5_pkg::rsp_t got);
			md5_pkg::rsp_t want;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("digest word %h idx %0d last %0b with nothing pending",
						got.digest_word, got.word_index, got.last);
			end else begin
				want = expected_words.pop_front();
				if (got.digest_word !== want.digest_word || got.word_index !== want.word_index
						|| got.last !== want.last) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
							want.digest_word, want.word_index, want.last,
							got.digest_word, got.word_index, got.last);
				end
			end
		endfunction

		function int outstanding();
			return expected_words.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	md5_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	md5_pkg::rsp_t rsp;

	digest_scoreboard sb = new();
	int burst_left = 0;
	int words_sent = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int idle_cycles = 0;

	md5_hash_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_word(input md5_pkg::req_t w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				req_valid <= 1'b0;
				req <= 9'($urandom_range(0, 511));
				@(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_word(w);
		burst_left--;
		words_sent++;
	endtask

	// pattern: 0 random, 1 zeros, 2 ones, 3 mixed extremes, 4 ascending from 'a'
	task automatic send_message(input int len, input int pattern);
		md5_pkg::req_t w;
		for (int i = 0; i < len; i++) begin
			w.op = md5_pkg::OP_ABSORB;
			case (pattern)
				0: w.data_byte = 8'($urandom_range(0, 255));
				1: w.data_byte = 8'h00;
				2: w.data_byte = 8'hFF;
				3: w.data_byte = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
				default: w.data_byte = 8'(8'h61 + i);
			endcase
			send_word(w);
		end
		w.op = md5_pkg::OP_FINISH;
		w.data_byte = 8'($urandom_range(0, 255));
		send_word(w);
	endtask

	task automatic run_random_messages();
		int pick;
		int len;
		while (words_sent < WORD_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				len = $urandom_range(0, 20);
			else if (pick < 80)
				len = SPILL_LENGTHS[$urandom_range(0, 9)];
			else if (pick < 92)
				len = $urandom_range(21, 140);
			else
				len = 0;
			send_message(len, ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 4));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_word(rsp);
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			mode_left <= $urandom_range(10, 200);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 3) == 0);
			2: rsp_stall <= ($urandom_range(0, 3) != 0);
			default: rsp_stall <= ~rsp_stall;
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("md5_hash_engine verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_message(0, 0);
		send_message(1, 1);
		send_message(1, 2);
		send_message(3, 4);
		send_message(0, 0);
		send_message(2, 3);
		run_random_messages();
		req_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("md5_hash_engine verification clean");
		else
			$display("md5_hash_engine verification failed");
		$finish;
	end

endmodule
